// ===== rtl/core/fullwidth_digit_normalizer_defines.svh =====
// ----------------------------------------------------------------------------
// Fullwidth digit normalizer assertion macros
// Shared property wrappers for the checker of the normalizer.
// ----------------------------------------------------------------------------
`ifndef FULLWIDTH_DIGIT_NORMALIZER_DEFINES_SVH
`define FULLWIDTH_DIGIT_NORMALIZER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define FDN_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdn: same-cycle check failed");

// Consequent checked in the cycle after the antecedent
`define FDN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdn: next-cycle check failed");

`endif

// ===== rtl/core/fdn_pkg.sv =====
// ----------------------------------------------------------------------------
// Fullwidth digit normalizer package
// Byte constants, prefix codes, word types and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package fdn_pkg;

   // UTF-8 bytes of interest
   localparam logic [7:0] LEAD_BYTE   = 8'hEF;
   localparam logic [7:0] SECOND_BYTE = 8'hBC;
   localparam logic [7:0] DIGIT_LO    = 8'h90;
   localparam logic [7:0] DIGIT_HI    = 8'h99;
   localparam logic [7:0] DIGIT_BASE  = 8'h90;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;

   // Held prefix codes
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_EF   = 2'd1;
   localparam logic [1:0] HELD_EFBC = 2'd2;

   // Up to three output bytes per input byte
   localparam int MAX_BYTES = 3;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // One classified input word: the bytes it releases, in order
   typedef struct packed {
      logic [CNT_W-1:0]          cnt;
      logic [MAX_BYTES-1:0][7:0] data;
      logic                      last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/fdn_front.sv =====
// ----------------------------------------------------------------------------
// Fullwidth digit normalizer front end
// Accepts input words, tracks the held prefix and classifies each word into
// the list of bytes it releases.
// ----------------------------------------------------------------------------
`default_nettype none

module fdn_front import fdn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   input  wire q_stat_type q_stat,
   output logic            push,
   output entry_type       push_entry
);

   logic [1:0] held_ff;
   logic [1:0] held_in;
   logic [1:0] next_held;
   logic       accept;
   logic       digit;
   entry_type  ent;

   // Append one byte at the next free slot
   function automatic entry_type append(entry_type e, logic [7:0] b);
      entry_type r;
      r = e;
      unique case (e.cnt)
         2'd0:    r.data[0] = b;
         2'd1:    r.data[1] = b;
         2'd2:    r.data[2] = b;
         default: r.data[0] = e.data[0];
      endcase
      r.cnt = e.cnt + 2'd1;
      return r;
   endfunction

   // Release a held prefix as raw bytes
   function automatic entry_type flush(entry_type e, logic [1:0] h);
      entry_type r;
      r = e;
      if (h == HELD_EF) begin
         r = append(r, LEAD_BYTE);
      end else if (h == HELD_EFBC) begin
         r = append(r, LEAD_BYTE);
         r = append(r, SECOND_BYTE);
      end
      return r;
   endfunction

   // Classify the current byte against the held prefix
   always_comb begin
      ent       = '0;
      next_held = HELD_NONE;
      digit     = (req_data.in_byte >= DIGIT_LO) && (req_data.in_byte <= DIGIT_HI);
      priority if (held_ff == HELD_EF && req_data.in_byte == SECOND_BYTE) begin
         next_held = HELD_EFBC;
      end else if (held_ff == HELD_EFBC && digit) begin
         ent = append(ent, req_data.in_byte - DIGIT_BASE + ASCII_ZERO);
      end else begin
         ent = flush(ent, held_ff);
         if (req_data.in_byte == LEAD_BYTE) begin
            next_held = HELD_EF;
         end else begin
            ent = append(ent, req_data.in_byte);
         end
      end
      // End of string: drop nothing, flush whatever is still held
      if (req_data.in_last) begin
         ent       = flush(ent, next_held);
         next_held = HELD_NONE;
         ent.last  = 1'b1;
      end
   end

   assign req_stall  = q_stat.full;
   assign accept     = req_valid & ~req_stall;
   assign push       = accept && (ent.cnt != '0);
   assign push_entry = ent;
   assign held_in    = accept ? next_held : held_ff;

   // Advance the prefix state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fdn_queue.sv =====
// ----------------------------------------------------------------------------
// Fullwidth digit normalizer queue
// Short FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fdn_queue import fdn_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      head,
   output q_stat_type     q_stat
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff;
   logic [QCNT_W-1:0] cnt_in;
   logic              do_push;
   logic              do_pop;

   assign q_stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push & ~q_stat.full;
   assign do_pop       = pop & ~q_stat.empty;
   assign head         = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fdn_back.sv =====
// ----------------------------------------------------------------------------
// Fullwidth digit normalizer back end
// Unrolls each queued word into output bytes, one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module fdn_back import fdn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_stat_type q_stat,
   input  wire entry_type  head,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data
);

   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic [CNT_W-1:0] last_idx;
   logic             final_byte;
   logic             accept;

   assign rsp_valid  = ~q_stat.empty;
   assign last_idx   = head.cnt - 2'd1;
   assign final_byte = (idx_ff == last_idx);
   assign accept     = rsp_valid & ~rsp_stall;
   assign pop        = accept & final_byte;

   // Select the current byte of the head word
   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_data.out_byte = head.data[0];
         2'd1:    rsp_data.out_byte = head.data[1];
         2'd2:    rsp_data.out_byte = head.data[2];
         default: rsp_data.out_byte = head.data[0];
      endcase
      rsp_data.out_last = head.last & final_byte;
   end

   assign idx_in = accept ? (final_byte ? '0 : idx_ff + 2'd1) : idx_ff;

   // Advance the byte index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fullwidth_digit_normalizer.sv =====
// ----------------------------------------------------------------------------
// Fullwidth digit normalizer
// Rewrites a UTF-8 byte stream, mapping fullwidth digits EF BC 90..99 to
// ASCII '0'..'9' and passing every other byte through in order.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle and, while rsp_stall is low,
// delivers one output byte per cycle. A byte that completes or breaks a held
// EF / EF BC prefix, or that ends a string, may release up to three bytes at
// once; these are parked as one word in a four-entry queue and drained by the
// back end at one byte per unstalled cycle, so the input side stalls only when
// that queue is full. Each word is registered in the queue before its first
// output byte appears. A string's last output byte carries out_last; the last
// input byte of a string always produces at least one output byte.
`default_nettype none

module fullwidth_digit_normalizer import fdn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   q_stat_type q_stat;
   entry_type  push_entry;
   entry_type  head;
   logic       push;
   logic       pop;

   fdn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   fdn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   fdn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/fdn_checker.sv =====
// ----------------------------------------------------------------------------
// Fullwidth digit normalizer checker
// Port-level checks on reset, output hold and output progress.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fullwidth_digit_normalizer_defines.svh"

module fdn_checker import fdn_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic req_accept;
   logic plain_or_last;
   logic rsp_held;

   assign req_accept    = req_valid && !req_stall;
   assign plain_or_last = req_data.in_last || !req_data.in_byte[7];
   assign rsp_held      = rsp_valid && rsp_stall;

   // Come out of reset empty and ready
   `FDN_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // Hold a stalled output word
   `FDN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // An ASCII byte or a last byte always releases output next cycle
   `FDN_ASSERT_NEXT(a_emit_progress, clock, reset, req_accept && plain_or_last, rsp_valid)

endmodule

bind fullwidth_digit_normalizer fdn_checker u_fdn_checker (.*);

`default_nettype wire
